[src/tpr_pkg.sv]
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types and constants for the task priority ratio block.
// ----------------------------------------------------------------------------
package tpr_pkg;
  localparam int PRIO_W = 50;
  localparam int MODE_W = 5;
  localparam logic [MODE_W-1:0] MODE_RESET = 5'd14;
  localparam logic [MODE_W-1:0] MODE_FIRST_RATIO = 5'd1;
  localparam logic [MODE_W-1:0] MODE_LAST_GRP0 = 5'd4;
  localparam logic [MODE_W-1:0] MODE_LAST_GRP1 = 5'd8;
  localparam logic [MODE_W-1:0] MODE_LAST_RATIO = 5'd12;
  localparam logic REG_PRIORITY_MODE = 1'b0;
  localparam logic [PRIO_W-1:0] PRIO_MAXPOS = {1'b0, {(PRIO_W-1){1'b1}}};

  typedef struct packed {
    logic inf;
    logic neg;
  } flags_t;
endpackage

[src/tpr_front.sv]
// ----------------------------------------------------------------------------
// tpr_front
// Accepts task counts and reduces them to a numerator, denominator and flags.
// ----------------------------------------------------------------------------
module tpr_front import tpr_pkg::*; #(
  parameter int COUNT_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [MODE_W-1:0]       mode,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COUNT_BITS-1:0]   input_records,
  input  logic                    is_entry_task,
  input  logic [COUNT_BITS-1:0]   output_records,
  input  logic                    is_exit_task,
  output logic                    cls_valid,
  input  logic                    cls_ready,
  output logic [2*COUNT_BITS:0]   cls_num,
  output logic [2*COUNT_BITS:0]   cls_den,
  output flags_t                  cls_flags
);
  localparam int W = 2*COUNT_BITS + 1;

  logic [COUNT_BITS:0] a, b;
  logic [W-1:0] aa, bb, num_next, den_next;
  logic [COUNT_BITS-1:0] i2, o2;
  logic [1:0] grp, sub;
  logic [MODE_W-1:0] mm1;
  flags_t flags_next;

  assign in_ready = !cls_valid || cls_ready;

  always_comb begin
    a = {1'b0, input_records} + 1'b1;
    b = {1'b0, (is_exit_task ? {COUNT_BITS{1'b0}} : output_records)} + 1'b1;
    aa = W'(a) * W'(a);
    bb = W'(b) * W'(b);
    mm1 = mode - 1'b1;
    sub = mm1[1:0];
    grp = (mode <= MODE_LAST_GRP0) ? 2'd0 : (mode <= MODE_LAST_GRP1) ? 2'd1 : 2'd2;
    i2 = is_entry_task ? '0 : input_records;
    o2 = is_exit_task ? '0 : output_records;
    num_next = '0;
    den_next = W'(1);
    flags_next = '0;
    if (mode >= MODE_FIRST_RATIO && mode <= MODE_LAST_RATIO) begin
      if (is_entry_task) begin
        if (sub[1]) begin
          num_next = W'(1);
          den_next = (grp == 2'd2) ? bb : W'(b);
        end
      end else if (is_exit_task) begin
        if (sub[0]) num_next = (grp == 2'd1) ? aa : W'(a);
        else flags_next.inf = 1'b1;
      end else begin
        num_next = (grp == 2'd1) ? aa : W'(a);
        den_next = (grp == 2'd2) ? bb : W'(b);
      end
    end else begin
      if (i2 >= o2) begin
        num_next = W'(i2 - o2);
      end else begin
        num_next = W'(o2 - i2);
        flags_next.neg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (in_ready) begin
      cls_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cls_num <= num_next;
      cls_den <= den_next;
      cls_flags <= flags_next;
    end
  end
endmodule

[src/tpr_queue.sv]
// ----------------------------------------------------------------------------
// tpr_queue
// Two-entry FIFO between the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
module tpr_queue #(
  parameter int DATA_W = 52
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head
);
  logic [DATA_W-1:0] mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = count[1];
  assign not_empty = count != 2'd0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem[wr_ptr] <= push_data;
  end
endmodule

[src/tpr_back.sv]
// ----------------------------------------------------------------------------
// tpr_back
// Pipelined restoring divider, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module tpr_back import tpr_pkg::*; #(
  parameter int COUNT_BITS = 12,
  parameter int FRAC_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    src_valid,
  output logic                    src_ready,
  input  logic [2*COUNT_BITS:0]   src_num,
  input  logic [2*COUNT_BITS:0]   src_den,
  input  flags_t                  src_flags,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PRIO_W-1:0]       priority_value,
  output logic                    is_infinite
);
  localparam int DW = 2*COUNT_BITS + 1;
  localparam int QW = DW + FRAC_BITS;
  localparam int CW = (QW > PRIO_W) ? QW : PRIO_W;
  localparam int NS = QW;

  logic [NS:0] vld;
  logic [DW-1:0] rem [NS+1];
  logic [DW-1:0] den [NS+1];
  logic [QW-1:0] sr [NS+1];
  flags_t flg [NS+1];
  logic adv;

  assign adv = !vld[NS] || out_ready;
  assign src_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-1:0], src_valid};
    end
    if (adv) begin
      rem[0] <= '0;
      den[0] <= src_den;
      sr[0] <= {src_num, {FRAC_BITS{1'b0}}};
      flg[0] <= src_flags;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW:0] t;
    logic ge;
    always_comb begin
      t = {rem[k], sr[k][QW-1]};
      ge = t >= {1'b0, den[k]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= ge ? DW'(t - {1'b0, den[k]}) : DW'(t);
        den[k+1] <= den[k];
        sr[k+1] <= {sr[k][QW-2:0], ge};
        flg[k+1] <= flg[k];
      end
    end
  end

  logic [CW-1:0] qx;
  logic [PRIO_W-1:0] mag;

  always_comb begin
    qx = CW'(sr[NS]);
    mag = (qx > CW'(PRIO_MAXPOS)) ? PRIO_MAXPOS : qx[PRIO_W-1:0];
    if (flg[NS].inf) priority_value = PRIO_MAXPOS;
    else if (flg[NS].neg) priority_value = PRIO_W'(-mag);
    else priority_value = mag;
  end

  assign is_infinite = flg[NS].inf;
  assign out_valid = vld[NS];
endmodule

[src/task_priority_ratio_top.sv]
// ----------------------------------------------------------------------------
// task_priority_ratio_top
// Scheduling priority from task record counts, signed fixed point output.
// ----------------------------------------------------------------------------
// Accepts one task per cycle while in_ready is high and returns one
// priority per task, in order. The path is one classify stage, the
// queue, and a restoring divider with one quotient bit per pipeline
// stage. Throughput is one item per cycle unless out_ready stalls it.
module task_priority_ratio_top import tpr_pkg::*; #(
  parameter int COUNT_BITS = 12,
  parameter int FRAC_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [COUNT_BITS-1:0]        input_records,
  input  logic                         is_entry_task,
  input  logic [COUNT_BITS-1:0]        output_records,
  input  logic                         is_exit_task,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PRIO_W-1:0]     priority_value,
  output logic                         is_infinite
);
  localparam int DW = 2*COUNT_BITS + 1;
  localparam int QD = 2*DW + $bits(flags_t);

  logic [MODE_W-1:0] priority_mode;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_mode <= MODE_RESET;
    end else if (wr && paddr[2] == REG_PRIORITY_MODE) begin
      priority_mode <= pwdata[MODE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PRIORITY_MODE) ? 32'(priority_mode) : 32'd0;

  logic cls_valid, cls_ready, q_full, q_ne, q_pop;
  logic [DW-1:0] cls_num, cls_den;
  flags_t cls_flags;
  logic [QD-1:0] q_head;
  logic [PRIO_W-1:0] pv;

  tpr_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk, .rst, .mode(priority_mode),
    .in_valid, .in_ready, .input_records, .is_entry_task,
    .output_records, .is_exit_task,
    .cls_valid, .cls_ready, .cls_num, .cls_den, .cls_flags
  );

  assign cls_ready = !q_full;

  tpr_queue #(.DATA_W(QD)) u_queue (
    .clk, .rst,
    .push(cls_valid && !q_full), .push_data({cls_flags, cls_den, cls_num}),
    .full(q_full), .pop(q_pop), .not_empty(q_ne), .head(q_head)
  );

  logic back_ready;
  assign q_pop = q_ne && back_ready;

  tpr_back #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst,
    .src_valid(q_ne), .src_ready(back_ready),
    .src_num(q_head[DW-1:0]), .src_den(q_head[2*DW-1:DW]),
    .src_flags(flags_t'(q_head[QD-1:2*DW])),
    .out_valid, .out_ready, .priority_value(pv), .is_infinite
  );

  assign priority_value = pv;

  a_inf_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_infinite |-> pv == PRIO_MAXPOS)
    else $error("infinite priority not at max");
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !wr |=> $stable(priority_mode))
    else $error("mode changed without write");
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
endmodule
